FILE: design/veh_pkg.sv
// ----------------------------------------------------------------------------
// veh_pkg: shared codes for the variable edge histogram
// Action codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package veh_pkg;

  localparam logic [1:0] ACT_ADD_EDGE = 2'd0;
  localparam logic [1:0] ACT_SAMPLE   = 2'd1;
  localparam logic [1:0] ACT_READ     = 2'd2;
  localparam logic [1:0] ACT_CLEAR    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_LOCKED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BELOW    = 3'd4;
  localparam logic [2:0] ST_ABOVE    = 3'd5;
  localparam logic [2:0] ST_BAD_BIN  = 3'd6;

  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

endpackage

FILE: design/veh_stream_if.sv
// ----------------------------------------------------------------------------
// veh_stream_if: valid/ready channel
// Carries one payload of type payload_t under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface veh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/variable_edge_histogram_unit.sv
// ----------------------------------------------------------------------------
// variable_edge_histogram_unit: histogram with software-chosen bin edges
// Usage: items enter on in_ch (action, value, bin_select); one result per
// item leaves on out_ch. Configuration writes (cfg_we, cfg_index, cfg_data)
// set low_bound and high_bound and belong only where no item is in flight.
// One item is in work at a time. Edge table and counts live in two memories
// with registered reads. A sample below or above the bounds or with no
// bins, a bad read, or an out-of-range or locked edge goes straight to the
// result register; read bin reads the count memory first. A sample in range
// takes a binary search over the sorted edge table, up to log2(MAX_EDGES)+1
// steps, plus the count read-modify-write. An add-edge item scans and shifts
// the table. A clear sweeps the count memory and seeds the bounds. After
// reset the table is empty and nothing needs clearing: counts are zero
// through per-entry valid bits and the first clear. The result sits in an
// output register; the next item is accepted while it waits, but work on it
// holds until out_ch takes the previous result.
// ----------------------------------------------------------------------------
module variable_edge_histogram_unit #(
  parameter int MAX_EDGES  = 64,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  veh_stream_if.sink   in_ch,
  veh_stream_if.source out_ch,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam logic [VALUE_BITS-1:0] VSIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRCH   = 4'd1;  // binary search issue
  localparam logic [3:0] S_SWAIT  = 4'd2;  // binary search compare
  localparam logic [3:0] S_CRD    = 4'd3;  // count read
  localparam logic [3:0] S_CWR    = 4'd4;  // count write
  localparam logic [3:0] S_SCAN   = 4'd5;  // edge scan issue
  localparam logic [3:0] S_SCMP   = 4'd6;  // edge scan compare
  localparam logic [3:0] S_SHIFT  = 4'd7;  // shift issue
  localparam logic [3:0] S_SHWR   = 4'd8;  // shift write
  localparam logic [3:0] S_CLR    = 4'd9;  // clear sweep
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_RDW    = 4'd11; // read bin wait

  // input item; the value is held in key with its sign bit flipped
  logic [1:0]            act;
  logic [VALUE_BITS-1:0] key;
  logic [5:0]            sel;

  logic [VALUE_BITS-1:0] low_bound, high_bound;
  logic [VALUE_BITS-1:0] lo_key, hi_key;
  assign lo_key = low_bound ^ VSIGN;
  assign hi_key = high_bound ^ VSIGN;

  logic [VALUE_BITS-1:0] edge_mem [MAX_EDGES];
  logic [COUNT_BITS-1:0] cnt_mem  [MAX_EDGES];
  logic [MAX_EDGES-1:0]  cnt_ok;   // entry valid since reset
  logic [VALUE_BITS-1:0] edge_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  cnt_rd_ok;

  logic [3:0]  state;
  logic [EW-1:0] edges_used;
  logic          locked;
  logic [COUNT_BITS-1:0] under_total, over_total, sample_total;

  // search bounds: low/high index, plus general pointer
  logic [EW:0]   s_lo, s_hi;
  logic [EW:0]   ptr;
  logic [EW:0]   mid;
  logic [AW-1:0] e_raddr, c_addr, e_waddr;
  logic          e_we, c_we;
  logic [VALUE_BITS-1:0] e_wdata;
  logic [COUNT_BITS-1:0] c_wdata;
  logic          pend;      // item waiting in act/key/sel
  logic          clr_hi;    // clear still owes the high edge

  logic [2:0]            r_status;
  logic [5:0]            r_bidx;
  logic [COUNT_BITS-1:0] r_bcnt;
  logic                  out_valid;

  logic [EW:0] nbins;
  assign nbins = (edges_used >= EW'(2)) ? ({1'b0, edges_used} - (EW+1)'(1)) : '0;
  assign mid = (s_lo + s_hi) >> 1;

  assign in_ch.ready = !pend;

  always_ff @(posedge clk) begin
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    edge_rd <= edge_mem[e_raddr];
    if (c_we) cnt_mem[c_addr] <= c_wdata;
    cnt_rd <= cnt_mem[c_addr];
    cnt_rd_ok <= cnt_ok[c_addr];
  end

  logic [COUNT_BITS-1:0] cnt_cur;
  assign cnt_cur = cnt_rd_ok ? cnt_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pend <= 1'b0; out_valid <= 1'b0;
      edges_used <= '0; locked <= 1'b0; cnt_ok <= '0;
      under_total <= '0; over_total <= '0; sample_total <= '0;
      low_bound <= '0; high_bound <= VALUE_BITS'(65536);
      clr_hi <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == veh_pkg::REG_LOW) low_bound <= cfg_data;
        else high_bound <= cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        pend <= 1'b1;
        act  <= in_ch.payload.action;
        key  <= VALUE_BITS'(in_ch.payload.value) ^ VSIGN;
        sel  <= in_ch.payload.bin_select;
      end
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      if (c_we) cnt_ok[c_addr] <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (pend && !(out_valid && !out_ch.ready)) begin
            unique case (act)
              veh_pkg::ACT_ADD_EDGE: begin
                r_bidx <= '0; r_bcnt <= '0;
                if (key < lo_key || key > hi_key) begin
                  r_status <= veh_pkg::ST_RANGE; state <= S_OUT;
                end else if (locked) begin
                  r_status <= veh_pkg::ST_LOCKED; state <= S_OUT;
                end else begin
                  r_status <= veh_pkg::ST_OK; ptr <= '0; state <= S_SCAN;
                end
              end
              veh_pkg::ACT_SAMPLE: begin
                r_bidx <= '0; r_bcnt <= '0;
                locked <= 1'b1;
                sample_total <= (sample_total == CMAX) ? CMAX : sample_total + 1'b1;
                if (key < lo_key) begin
                  under_total <= (under_total == CMAX) ? CMAX : under_total + 1'b1;
                  r_status <= veh_pkg::ST_BELOW; state <= S_OUT;
                end else if (key >= hi_key) begin
                  over_total <= (over_total == CMAX) ? CMAX : over_total + 1'b1;
                  r_status <= veh_pkg::ST_ABOVE; state <= S_OUT;
                end else if (nbins == '0) begin
                  r_status <= veh_pkg::ST_BAD_BIN; state <= S_OUT;
                end else begin
                  // find largest i < nbins+1 with edge[i] <= key
                  r_status <= veh_pkg::ST_OK;
                  s_lo <= '0; s_hi <= nbins + (EW+1)'(1);
                  ptr <= nbins + (EW+1)'(1);  // none found yet
                  state <= S_SRCH;
                end
              end
              veh_pkg::ACT_READ: begin
                r_bidx <= sel; r_bcnt <= '0;
                if ((EW+1)'(sel) < nbins) begin
                  r_status <= veh_pkg::ST_OK;
                  ptr <= (EW+1)'(sel); state <= S_RDW;
                end else begin
                  r_status <= veh_pkg::ST_BAD_BIN; state <= S_OUT;
                end
              end
              default: begin
                r_status <= veh_pkg::ST_OK; r_bidx <= '0; r_bcnt <= '0;
                edges_used <= '0; locked <= 1'b0;
                under_total <= '0; over_total <= '0; sample_total <= '0;
                ptr <= '0; state <= S_CLR;
              end
            endcase
          end
        end
        S_RDW: state <= S_CRD;
        S_CRD: begin
          // sample: write back the incremented count; read: return it
          if (act == veh_pkg::ACT_SAMPLE) begin
            r_bcnt <= (cnt_cur == CMAX) ? CMAX : cnt_cur + 1'b1;
            state <= S_CWR;
          end else begin
            r_bcnt <= cnt_cur; state <= S_OUT;
          end
        end
        S_SRCH: begin
          if (s_lo < s_hi) state <= S_SWAIT;
          else if (ptr > nbins || ptr == nbins) begin
            r_status <= veh_pkg::ST_BAD_BIN; state <= S_OUT;
          end else begin
            r_bidx <= 6'(ptr); state <= S_RDW;
          end
        end
        S_SWAIT: begin
          if (edge_rd <= key) begin
            ptr <= mid; s_lo <= mid + (EW+1)'(1);
          end else begin
            s_hi <= mid;
          end
          state <= S_SRCH;
        end
        S_CWR: state <= S_OUT;
        S_SCAN: begin
          if (ptr < (EW+1)'(edges_used)) state <= S_SCMP;
          else if ({1'b0, edges_used} >= (EW+1)'(MAX_EDGES)) begin
            r_status <= veh_pkg::ST_FULL; state <= S_OUT;
          end else begin
            s_hi <= (EW+1)'(edges_used); state <= S_SHIFT;
          end
        end
        S_SCMP: begin
          if (edge_rd == key) begin
            state <= S_OUT;
          end else if (edge_rd > key) begin
            if ({1'b0, edges_used} >= (EW+1)'(MAX_EDGES)) begin
              r_status <= veh_pkg::ST_FULL; state <= S_OUT;
            end else begin
              s_hi <= (EW+1)'(edges_used); state <= S_SHIFT;
            end
          end else begin
            ptr <= ptr + (EW+1)'(1); state <= S_SCAN;
          end
        end
        S_SHIFT: begin
          // s_hi walks down from edges_used to ptr, moving entries up
          if (s_hi == ptr) begin
            edges_used <= edges_used + EW'(1);
            if (act == veh_pkg::ACT_CLEAR && clr_hi) begin
              clr_hi <= 1'b0; ptr <= '0; key <= hi_key; state <= S_SCAN;
            end else state <= S_OUT;
          end else state <= S_SHWR;
        end
        S_SHWR: begin
          s_hi <= s_hi - (EW+1)'(1); state <= S_SHIFT;
        end
        S_CLR: begin
          if (ptr == (EW+1)'(MAX_EDGES - 1)) begin
            key <= lo_key; clr_hi <= (hi_key > lo_key);
            ptr <= '0; s_hi <= '0; state <= S_SHIFT;
          end else ptr <= ptr + (EW+1)'(1);
        end
        S_OUT: begin
          out_valid <= 1'b1; pend <= 1'b0; clr_hi <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory port control
  always_comb begin
    e_raddr = AW'(ptr);
    if (state == S_SRCH) e_raddr = AW'(mid);
    else if (state == S_SHIFT) e_raddr = AW'(s_hi - (EW+1)'(1));
    e_we    = 1'b0;
    e_waddr = AW'(s_hi);
    e_wdata = edge_rd;
    if (state == S_SHWR) e_we = 1'b1;
    if (state == S_SHIFT && s_hi == ptr) begin
      e_we = 1'b1; e_wdata = key; e_waddr = AW'(ptr);
    end
    c_addr  = AW'(ptr);
    c_we    = 1'b0;
    c_wdata = (cnt_cur == CMAX) ? CMAX : cnt_cur + 1'b1;
    if (state == S_CLR) begin
      c_we = 1'b1; c_wdata = '0;
    end else if (state == S_CRD && act == veh_pkg::ACT_SAMPLE) begin
      c_we = 1'b1;
    end
  end

  assign out_ch.valid               = out_valid;
  assign out_ch.payload.status      = r_status;
  assign out_ch.payload.bin_index   = r_bidx;
  assign out_ch.payload.bin_count   = 32'(r_bcnt);
  assign out_ch.payload.below_count = 32'(under_total);
  assign out_ch.payload.above_count = 32'(over_total);
  assign out_ch.payload.total_count = 32'(sample_total);
  assign out_ch.payload.edge_count  = 7'(edges_used);

endmodule

FILE: verif/veh_tb_types_pkg.sv
// ----------------------------------------------------------------------------
// veh_tb_types_pkg: item layouts for the histogram testbench
// Payload structs carried on the input and output channels.
// ----------------------------------------------------------------------------
package veh_tb_types_pkg;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
    logic [5:0]         bin_select;
  } hist_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  bin_index;
    logic [31:0] bin_count;
    logic [31:0] below_count;
    logic [31:0] above_count;
    logic [31:0] total_count;
    logic [6:0]  edge_count;
  } hist_rsp_t;

endpackage

FILE: verif/veh_histogram_checker.sv
// ----------------------------------------------------------------------------
// veh_histogram_checker: response predictor and scoreboard
// Mirrors the edge table, bin counts and totals from observed items and
// register writes, and compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module veh_histogram_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  veh_tb_types_pkg::hist_req_t  in_item,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  veh_tb_types_pkg::hist_rsp_t  out_item,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [31:0]                  cfg_data,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_EDGES = 64;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  logic [31:0] low_reg, high_reg;
  logic [31:0] edge_keys [NUM_EDGES];
  logic [31:0] bin_tally [NUM_EDGES];
  int          edges_used;
  logic        locked;
  logic [31:0] below_tot, above_tot, sample_tot;
  veh_tb_types_pkg::hist_rsp_t expected_rsps[$];

  function automatic logic [31:0] sat_inc(logic [31:0] c);
    return (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

  function automatic void insert_key(logic [31:0] k);
    int pos;
    pos = 0;
    while (pos < edges_used && edge_keys[pos] < k) pos++;
    if (pos < edges_used && edge_keys[pos] == k) return;
    if (edges_used >= NUM_EDGES) return;
    for (int i = edges_used; i > pos; i--) edge_keys[i] = edge_keys[i-1];
    edge_keys[pos] = k;
    edges_used++;
  endfunction

  function automatic veh_tb_types_pkg::hist_rsp_t predict_histogram(
    veh_tb_types_pkg::hist_req_t req);
    veh_tb_types_pkg::hist_rsp_t r;
    logic [31:0] x, lo, hi;
    int          nbins, found;
    bit          present;
    r = '0;
    x = req.value ^ 32'h8000_0000;
    lo = low_reg ^ 32'h8000_0000;
    hi = high_reg ^ 32'h8000_0000;
    nbins = (edges_used >= 2) ? edges_used - 1 : 0;
    r.status = veh_pkg::ST_OK;
    case (req.action)
      veh_pkg::ACT_ADD_EDGE: begin
        present = 0;
        for (int i = 0; i < edges_used; i++) if (edge_keys[i] == x) present = 1;
        if (x < lo || x > hi) r.status = veh_pkg::ST_RANGE;
        else if (locked) r.status = veh_pkg::ST_LOCKED;
        else if (present) r.status = veh_pkg::ST_OK;
        else if (edges_used >= NUM_EDGES) r.status = veh_pkg::ST_FULL;
        else insert_key(x);
      end
      veh_pkg::ACT_SAMPLE: begin
        locked = 1;
        sample_tot = sat_inc(sample_tot);
        if (x < lo) begin
          below_tot = sat_inc(below_tot);
          r.status = veh_pkg::ST_BELOW;
        end else if (x >= hi) begin
          above_tot = sat_inc(above_tot);
          r.status = veh_pkg::ST_ABOVE;
        end else begin
          found = nbins;
          for (int i = 0; i < nbins; i++) begin
            if (found == nbins && edge_keys[i] <= x && x < edge_keys[i+1]) found = i;
          end
          if (found < nbins) begin
            bin_tally[found] = sat_inc(bin_tally[found]);
            r.bin_index = found[5:0];
            r.bin_count = bin_tally[found];
          end else begin
            r.status = veh_pkg::ST_BAD_BIN;
          end
        end
      end
      veh_pkg::ACT_READ: begin
        r.bin_index = req.bin_select;
        if (int'(req.bin_select) < nbins) r.bin_count = bin_tally[req.bin_select];
        else r.status = veh_pkg::ST_BAD_BIN;
      end
      default: begin
        for (int i = 0; i < NUM_EDGES; i++) begin
          bin_tally[i] = '0;
          edge_keys[i] = '0;
        end
        edges_used = 0;
        locked = 0;
        below_tot = '0;
        above_tot = '0;
        sample_tot = '0;
        insert_key(lo);
        if (hi > lo) insert_key(hi);
      end
    endcase
    r.below_count = below_tot;
    r.above_count = above_tot;
    r.total_count = sample_tot;
    r.edge_count = edges_used[6:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign pending = expected_rsps.size();

  always @(posedge clk) begin
    veh_tb_types_pkg::hist_rsp_t e;
    if (rst) begin
      errors = 0;
      low_reg = '0;
      high_reg = 32'd65536;
      edges_used = 0;
      locked = 0;
      below_tot = '0;
      above_tot = '0;
      sample_tot = '0;
      for (int i = 0; i < NUM_EDGES; i++) bin_tally[i] = '0;
      expected_rsps.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == veh_pkg::REG_LOW) low_reg = cfg_data;
        else high_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no item outstanding");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          compare_field("status", e.status, out_item.status);
          compare_field("bin_index", e.bin_index, out_item.bin_index);
          compare_field("bin_count", e.bin_count, out_item.bin_count);
          compare_field("below_count", e.below_count, out_item.below_count);
          compare_field("above_count", e.above_count, out_item.above_count);
          compare_field("total_count", e.total_count, out_item.total_count);
          compare_field("edge_count", e.edge_count, out_item.edge_count);
        end
      end
      if (in_valid && in_ready)
        expected_rsps.insert(expected_rsps.size(), predict_histogram(in_item));
    end
  end

endmodule

FILE: verif/tb_variable_edge_histogram_unit.sv
// ----------------------------------------------------------------------------
// tb_variable_edge_histogram_unit: testbench top for the edge histogram
// Drives directed and random edge, sample, read and clear items over a
// range of bound settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_variable_edge_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int ITEM_GOAL = 550;

  logic        clk, rst;
  logic        cfg_we, cfg_index;
  logic [31:0] cfg_data;
  int          errors, pending;
  int          items_sent, samples_sent, phases_run, idle_cycles;
  bit          quiet;
  int          ready_hold;

  veh_stream_if #(.payload_t(veh_tb_types_pkg::hist_req_t)) in_ch ();
  veh_stream_if #(.payload_t(veh_tb_types_pkg::hist_rsp_t)) out_ch ();

  variable_edge_histogram_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  veh_histogram_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Stall the response side in short bursts.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ch.ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [31:0] val, logic [5:0] sel);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= '{action: act, value: val, bin_select: sel};
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (act == veh_pkg::ACT_SAMPLE) samples_sent++;
  endtask

  // Drain all responses, then let the unit settle before a register write.
  task automatic write_bounds(logic [31:0] lo, logic [31:0] hi);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (140) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= veh_pkg::REG_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= veh_pkg::REG_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  function automatic logic [31:0] pick_in_range(logic [31:0] lo, logic [31:0] hi);
    longint l, h;
    l = longint'($signed(lo));
    h = longint'($signed(hi));
    if (h <= l) return lo;
    return 32'(l + (longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (h - l + 1)));
  endfunction

  // Clear, load edges, then mostly in-range samples with reads and noise.
  task automatic run_phase(logic [31:0] lo, logic [31:0] hi, int n_edges, int n_ops);
    longint span;
    logic [31:0] v;
    write_bounds(lo, hi);
    send_item(veh_pkg::ACT_CLEAR, $urandom, 6'($urandom));
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(veh_pkg::ACT_ADD_EDGE, $urandom, 6'($urandom));
      else send_item(veh_pkg::ACT_ADD_EDGE, pick_in_range(lo, hi), 6'($urandom));
    end
    span = longint'($signed(hi)) - longint'($signed(lo));
    for (int i = 0; i < n_ops; i++) begin
      case ($urandom_range(0, 9))
        0: send_item(veh_pkg::ACT_READ, $urandom, 6'($urandom_range(0, 63)));
        1: send_item(veh_pkg::ACT_READ, $urandom, 6'($urandom_range(0, n_edges + 1)));
        2: send_item(veh_pkg::ACT_ADD_EDGE, pick_in_range(lo, hi), 6'($urandom));
        3: send_item(veh_pkg::ACT_SAMPLE, $urandom, 6'($urandom));
        4: begin
          v = (span > 2) ? 32'(longint'($signed(lo)) - $urandom_range(1, 3))
                         : $urandom;
          send_item(veh_pkg::ACT_SAMPLE, $urandom_range(0, 1) ? v : hi, 6'($urandom));
        end
        default: send_item(veh_pkg::ACT_SAMPLE, pick_in_range(lo, hi), 6'($urandom));
      endcase
    end
  endtask

  initial begin
    logic [31:0] lo, hi;
    rst = 1;
    cfg_we = 0;
    cfg_index = veh_pkg::REG_LOW;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.payload = '0;
    out_ch.ready = 1;
    quiet = 0;
    items_sent = 0;
    samples_sent = 0;
    phases_run = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Before any clear: no bins exist, samples lock edges, reads find nothing.
    send_item(veh_pkg::ACT_SAMPLE, 32'd100, 6'd0);
    send_item(veh_pkg::ACT_SAMPLE, 32'hFFFF_FFFF, 6'd0);
    send_item(veh_pkg::ACT_SAMPLE, 32'd65536, 6'd0);
    send_item(veh_pkg::ACT_READ, 32'd0, 6'd63);
    send_item(veh_pkg::ACT_ADD_EDGE, 32'd5, 6'd0);
    send_item(veh_pkg::ACT_CLEAR, 32'd0, 6'd0);
    send_item(veh_pkg::ACT_ADD_EDGE, 32'd32768, 6'd0);
    send_item(veh_pkg::ACT_ADD_EDGE, 32'd32768, 6'd0);
    send_item(veh_pkg::ACT_ADD_EDGE, 32'd70000, 6'd0);
    send_item(veh_pkg::ACT_ADD_EDGE, 32'd65536, 6'd0);
    send_item(veh_pkg::ACT_SAMPLE, 32'd0, 6'd0);
    send_item(veh_pkg::ACT_SAMPLE, 32'd65535, 6'd0);
    send_item(veh_pkg::ACT_ADD_EDGE, 32'd100, 6'd0);
    send_item(veh_pkg::ACT_READ, 32'd0, 6'd1);
    send_item(veh_pkg::ACT_READ, 32'd0, 6'd2);

    // Full range with the table filled past capacity.
    run_phase(32'h8000_0000, 32'h7FFF_FFFF, 70, 30);
    send_item(veh_pkg::ACT_SAMPLE, 32'h8000_0000, 6'd0);
    send_item(veh_pkg::ACT_SAMPLE, 32'h7FFF_FFFF, 6'd0);
    // Bounds equal and reversed: one edge, no bins.
    run_phase(32'd5, 32'd5, 3, 6);
    run_phase(32'd10, 32'hFFFF_FFF6, 3, 6);
    // Registers moved after a clear: in-range samples held by no bin.
    run_phase(32'hFFFF_FF9C, 32'd100, 6, 10);
    write_bounds(32'hFFFF_0000, 32'd200000);
    for (int i = 0; i < 6; i++)
      send_item(veh_pkg::ACT_SAMPLE, pick_in_range(32'hFFFF_0000, 32'd200000), 6'd0);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent > ITEM_GOAL - 80) quiet = 1;
      lo = $urandom;
      hi = pick_in_range(lo, 32'h7FFF_FFFF);
      if ($urandom_range(0, 2) == 0) begin
        lo = $urandom_range(0, 200) - 100;
        hi = lo + $urandom_range(1, 300);
      end
      run_phase(lo, hi, $urandom_range(0, 12), $urandom_range(10, 40));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (150) @(posedge clk);
    $display("Covered %0d items (%0d samples) across %0d bound settings,",
             items_sent, samples_sent, phases_run);
    $display("including full, equal and reversed ranges and a table past capacity.");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
